// File: rtl/core/kedq_pkg.sv
package kedq_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int ID_W     = 16;
   localparam int STAMP_W  = 32;
   localparam int SEQ_W    = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_POST_BACK  = 2'd0,
      CMD_POST_FRONT = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_CLEAR      = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_UNKNOWN    = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_MISMATCH   = 3'd3,
      ST_TABLE_FULL = 3'd4,
      ST_QUEUE_FULL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_POST   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               at_front;
      logic [KEY_W-1:0]   object_key;
      logic [ID_W-1:0]    event_id;
      logic [STAMP_W-1:0] time_stamp;
   } task_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SCAN   = 3'd1,
      S_DECIDE = 3'd2,
      S_EXEC   = 3'd3,
      S_CHECK  = 3'd4,
      S_FINISH = 3'd5
   } state_type;

endpackage

// File: rtl/core/kedq_if.sv
interface kedq_req_if;
   logic                          valid;
   logic                          ready;
   logic [kedq_pkg::CMD_W-1:0]   command;
   logic [kedq_pkg::KEY_W-1:0]   object_key;
   logic [kedq_pkg::ID_W-1:0]    event_id;
   logic [kedq_pkg::STAMP_W-1:0] time_stamp;

   modport source (output valid, output command, output object_key, output event_id,
                   output time_stamp, input ready);
   modport sink   (input valid, input command, input object_key, input event_id,
                   input time_stamp, output ready);
endinterface

interface kedq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [kedq_pkg::SEQ_W-1:0]    sequence_number;
   logic [kedq_pkg::STAMP_W-1:0]  stamp_out;
   logic [kedq_pkg::STATUS_W-1:0] status;

   modport source (output valid, output sequence_number, output stamp_out, output status,
                   input ready);
   modport sink   (input valid, input sequence_number, input stamp_out, input status,
                   output ready);
endinterface

// File: rtl/core/kedq_ram.sv
module kedq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/kedq_front.sv
module kedq_front #(
   parameter int ID_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   kedq_req_if.sink           req_bus,
   output logic               task_valid,
   input  logic               task_ready,
   output kedq_pkg::task_type task_item
);

   localparam int IdW = (ID_BITS < kedq_pkg::ID_W) ? ID_BITS : kedq_pkg::ID_W;
   localparam logic [kedq_pkg::ID_W-1:0] IdMask = {kedq_pkg::ID_W{1'b1}} >> (kedq_pkg::ID_W - IdW);

   kedq_pkg::task_type slot_ff [2];
   kedq_pkg::task_type slot_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               push, pop;

   // classify the incoming item
   always_comb begin
      slot_in.object_key = req_bus.object_key;
      slot_in.event_id   = req_bus.event_id & IdMask;
      slot_in.time_stamp = req_bus.time_stamp;
      slot_in.op         = kedq_pkg::OP_POST;
      slot_in.at_front   = 1'b0;
      unique case (kedq_pkg::command_type'(req_bus.command))
         kedq_pkg::CMD_POST_BACK: begin
            slot_in.op = kedq_pkg::OP_POST;
         end
         kedq_pkg::CMD_POST_FRONT: begin
            slot_in.op       = kedq_pkg::OP_POST;
            slot_in.at_front = 1'b1;
         end
         kedq_pkg::CMD_REMOVE: begin
            slot_in.op = kedq_pkg::OP_REMOVE;
         end
         kedq_pkg::CMD_CLEAR: begin
            slot_in.op = kedq_pkg::OP_CLEAR;
         end
         default: begin
            slot_in.op = kedq_pkg::OP_CLEAR;
         end
      endcase
   end

   assign req_bus.ready = (fill_ff != 2'd2);
   assign task_valid    = (fill_ff != 2'd0);
   assign task_item     = slot_ff[rd_ptr_ff];
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = task_valid && task_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// File: rtl/core/kedq_back.sv
module kedq_back #(
   parameter int NUM_KEYS    = 16,
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               task_valid,
   output logic               task_ready,
   input  kedq_pkg::task_type task_item,
   kedq_rsp_if.source         rsp_bus
);

   localparam int IdW   = (ID_BITS < kedq_pkg::ID_W) ? ID_BITS : kedq_pkg::ID_W;
   localparam int KA    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int KC    = $clog2(NUM_KEYS + 1);
   localparam int QA    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CA    = $clog2(QUEUE_DEPTH + 1);
   localparam int Slots = NUM_KEYS * QUEUE_DEPTH;
   localparam int EA    = (Slots > 1) ? $clog2(Slots) : 1;

   typedef struct packed {
      logic [kedq_pkg::KEY_W-1:0] key;
      logic [kedq_pkg::SEQ_W-1:0] seq;
      logic [QA-1:0]              head;
      logic [CA-1:0]              count;
   } rec_type;

   typedef struct packed {
      logic [IdW-1:0]                id;
      logic [kedq_pkg::STAMP_W-1:0] stamp;
      logic [kedq_pkg::SEQ_W-1:0]   seq;
   } event_type;

   localparam int RecW = $bits(rec_type);
   localparam int EvW  = $bits(event_type);

   kedq_pkg::state_type  state_ff, state_in;
   kedq_pkg::task_type   task_ff, task_in;
   logic [NUM_KEYS-1:0]  valid_ff, valid_in;
   logic [KC-1:0]        scan_ff, scan_in;
   logic [KC-1:0]        chk_ff, chk_in;
   logic                 issue_ff, issue_in;
   logic                 found_ff, found_in;
   logic                 free_found_ff, free_found_in;
   logic [KA-1:0]        free_idx_ff, free_idx_in;
   logic [KA-1:0]        kidx_ff, kidx_in;
   rec_type              rec_ff, rec_in;
   logic [EA-1:0]        base_ff, base_in;
   logic [kedq_pkg::SEQ_W-1:0]   res_seq_ff, res_seq_in;
   logic [kedq_pkg::STAMP_W-1:0] res_stamp_ff, res_stamp_in;
   kedq_pkg::status_type         res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kedq_pkg::SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [kedq_pkg::STAMP_W-1:0] rsp_stamp_ff, rsp_stamp_in;
   kedq_pkg::status_type         rsp_status_ff, rsp_status_in;

   rec_type       rec_rd_data, rec_wr_data, cur_rec;
   logic          rec_wr_en;
   logic [KA-1:0] rec_rd_addr, cur_idx, chk_idx;
   event_type     ev_rd_data, ev_wr_data;
   logic          ev_wr_en;
   logic [EA-1:0] ev_addr;

   logic          hit, last_chk, decide_fail, rsp_free;
   logic [QA-1:0] head_inc, head_dec, back_pos, pos;
   logic [QA+1:0] pos_sum;

   kedq_ram #(.WIDTH(RecW), .DEPTH(NUM_KEYS)) u_key_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (kidx_ff),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   kedq_ram #(.WIDTH(EvW), .DEPTH(Slots)) u_event_ram (
      .clock   (clock),
      .wr_en   (ev_wr_en),
      .wr_addr (ev_addr),
      .wr_data (ev_wr_data),
      .rd_addr (ev_addr),
      .rd_data (ev_rd_data)
   );

   // key lookup and slot arithmetic
   assign rec_rd_addr = scan_ff[KA-1:0];
   assign chk_idx     = chk_ff[KA-1:0];
   assign hit         = issue_ff && valid_ff[chk_idx] && (rec_rd_data.key == task_ff.object_key);
   assign last_chk    = issue_ff && (chk_ff == KC'(NUM_KEYS - 1));
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      cur_rec = rec_ff;
      cur_idx = kidx_ff;
      if (!found_ff) begin
         cur_rec.key   = task_ff.object_key;
         cur_rec.seq   = kedq_pkg::SEQ_W'(1);
         cur_rec.head  = '0;
         cur_rec.count = '0;
         cur_idx       = free_idx_ff;
      end
      if (task_ff.op == kedq_pkg::OP_REMOVE) begin
         decide_fail = !found_ff || (rec_ff.count == '0);
      end else begin
         decide_fail = (!found_ff && !free_found_ff) || (cur_rec.count == CA'(QUEUE_DEPTH));
      end
   end

   assign head_inc = (rec_ff.head == QA'(QUEUE_DEPTH - 1)) ? '0 : rec_ff.head + QA'(1);
   assign head_dec = (rec_ff.head == '0) ? QA'(QUEUE_DEPTH - 1) : rec_ff.head - QA'(1);
   assign pos_sum  = (QA+2)'(rec_ff.head) + (QA+2)'(rec_ff.count);
   assign back_pos = (pos_sum >= (QA+2)'(QUEUE_DEPTH)) ?
                     QA'(pos_sum - (QA+2)'(QUEUE_DEPTH)) : QA'(pos_sum);
   assign pos      = (task_ff.op == kedq_pkg::OP_REMOVE) ? rec_ff.head :
                     (task_ff.at_front ? head_dec : back_pos);
   assign ev_addr  = base_ff + EA'(pos);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kedq_pkg::S_IDLE: begin
            if (task_valid) begin
               state_in = (task_item.op == kedq_pkg::OP_CLEAR) ? kedq_pkg::S_FINISH
                                                                : kedq_pkg::S_SCAN;
            end
         end
         kedq_pkg::S_SCAN: begin
            if (hit || last_chk) begin
               state_in = kedq_pkg::S_DECIDE;
            end
         end
         kedq_pkg::S_DECIDE: begin
            state_in = decide_fail ? kedq_pkg::S_FINISH : kedq_pkg::S_EXEC;
         end
         kedq_pkg::S_EXEC: begin
            state_in = (task_ff.op == kedq_pkg::OP_REMOVE) ? kedq_pkg::S_CHECK
                                                           : kedq_pkg::S_FINISH;
         end
         kedq_pkg::S_CHECK: begin
            state_in = kedq_pkg::S_FINISH;
         end
         kedq_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = kedq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kedq_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      task_ready    = (state_ff == kedq_pkg::S_IDLE);
      task_in       = task_ff;
      valid_in      = valid_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      issue_in      = 1'b0;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      kidx_in       = kidx_ff;
      rec_in        = rec_ff;
      base_in       = base_ff;
      res_seq_in    = res_seq_ff;
      res_stamp_in  = res_stamp_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_seq_in    = rsp_seq_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_status_in = rsp_status_ff;
      rec_wr_en     = 1'b0;
      rec_wr_data   = rec_ff;
      ev_wr_en      = 1'b0;
      ev_wr_data.id    = task_ff.event_id[IdW-1:0];
      ev_wr_data.stamp = task_ff.time_stamp;
      ev_wr_data.seq   = rec_ff.seq;
      unique case (state_ff)
         kedq_pkg::S_IDLE: begin
            if (task_valid) begin
               task_in       = task_item;
               scan_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               res_seq_in    = '0;
               res_stamp_in  = '0;
               res_status_in = kedq_pkg::ST_OK;
               if (task_item.op == kedq_pkg::OP_CLEAR) begin
                  valid_in = '0;
               end
            end
         end
         kedq_pkg::S_SCAN: begin
            if (scan_ff < KC'(NUM_KEYS)) begin
               issue_in = 1'b1;
               chk_in   = scan_ff;
               scan_in  = scan_ff + KC'(1);
            end
            if (hit) begin
               found_in = 1'b1;
               kidx_in  = chk_idx;
               rec_in   = rec_rd_data;
               issue_in = 1'b0;
            end else if (issue_ff && !valid_ff[chk_idx] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx;
            end
            if (last_chk) begin
               issue_in = 1'b0;
            end
         end
         kedq_pkg::S_DECIDE: begin
            base_in = EA'(cur_idx * QUEUE_DEPTH);
            if (task_ff.op == kedq_pkg::OP_REMOVE) begin
               if (!found_ff) begin
                  res_status_in = kedq_pkg::ST_UNKNOWN;
               end else if (rec_ff.count == '0) begin
                  res_status_in = kedq_pkg::ST_EMPTY;
               end
            end else if (!found_ff && !free_found_ff) begin
               res_status_in = kedq_pkg::ST_TABLE_FULL;
            end else begin
               rec_in  = cur_rec;
               kidx_in = cur_idx;
               if (!found_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
               if (cur_rec.count == CA'(QUEUE_DEPTH)) begin
                  res_status_in = kedq_pkg::ST_QUEUE_FULL;
               end
            end
         end
         kedq_pkg::S_EXEC: begin
            rec_wr_en = 1'b1;
            if (task_ff.op == kedq_pkg::OP_REMOVE) begin
               rec_wr_data.head  = head_inc;
               rec_wr_data.count = rec_ff.count - CA'(1);
            end else begin
               ev_wr_en          = 1'b1;
               rec_wr_data.head  = task_ff.at_front ? head_dec : rec_ff.head;
               rec_wr_data.count = rec_ff.count + CA'(1);
               rec_wr_data.seq   = rec_ff.seq + kedq_pkg::SEQ_W'(1);
               res_seq_in        = rec_ff.seq;
               res_status_in     = kedq_pkg::ST_OK;
            end
         end
         kedq_pkg::S_CHECK: begin
            if (ev_rd_data.id == task_ff.event_id[IdW-1:0]) begin
               res_seq_in    = ev_rd_data.seq;
               res_stamp_in  = ev_rd_data.stamp;
               res_status_in = kedq_pkg::ST_OK;
            end else begin
               res_status_in = kedq_pkg::ST_MISMATCH;
            end
         end
         kedq_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_seq_in    = res_seq_ff;
               rsp_stamp_in  = res_stamp_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            task_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kedq_pkg::S_IDLE;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff       <= task_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      kidx_ff       <= kidx_in;
      rec_ff        <= rec_in;
      base_ff       <= base_in;
      res_seq_ff    <= res_seq_in;
      res_stamp_ff  <= res_stamp_in;
      res_status_ff <= res_status_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.sequence_number = rsp_seq_ff;
   assign rsp_bus.stamp_out       = rsp_stamp_ff;
   assign rsp_bus.status          = rsp_status_ff;

endmodule

// File: rtl/core/keyed_event_deque_table_unit.sv
// keyed event deque table: each item posts an event at the back or front of a key's
// deque, removes the front event, or clears the table, and gives exactly one result.
// a two-item queue at the input keeps taking items until it is full, also while the
// back end works and while a result waits in the output register. the back end finds
// the key by scanning the key table memory one slot per cycle and stops at a hit. an
// item whose key is found goes on through decide, exec and finish (a post) or decide,
// exec, check and finish (a remove), or from decide to finish when it is refused for
// an empty or a full queue; a post of a new key, a remove of an unknown key and a post
// to a full table scan the whole table first; a clear goes straight to finish. a
// result that waits for the output holds the back end. keys are allocated to the
// lowest free slot; event storage is one memory of NUM_KEYS * QUEUE_DEPTH entries and
// needs no clearing after reset.
module keyed_event_deque_table_unit #(
   parameter int NUM_KEYS    = 16,
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 16
) (
   input logic        clock,
   input logic        reset,
   kedq_req_if.sink   req_bus,
   kedq_rsp_if.source rsp_bus
);

   logic               task_valid;
   logic               task_ready;
   kedq_pkg::task_type task_item;

   kedq_front #(.ID_BITS(ID_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .task_valid (task_valid),
      .task_ready (task_ready),
      .task_item  (task_item)
   );

   kedq_back #(
      .NUM_KEYS    (NUM_KEYS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_ready (task_ready),
      .task_item  (task_item),
      .rsp_bus    (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status != kedq_pkg::ST_OK) |->
         (rsp_bus.sequence_number == '0) && (rsp_bus.stamp_out == '0))
      else $error("error result carries nonzero fields");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> task_valid)
      else $error("input stalled with no item queued for the back end");
`endif

endmodule
